// ===== rtl/asfp_pkg.sv =====
// Types and constants for the ASCII sensor frame parser.
// Used by ascii_sensor_frame_parser_unit; no other dependencies.
package asfp_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_START_BYTE  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_HEADER_WORD = 1'd1;

  localparam logic [7:0]  START_BYTE_RST  = 8'h31;
  localparam logic [31:0] HEADER_WORD_RST = 32'h3131_3136;

  // Frame layout
  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned FIELD_FIRST = 5;
  localparam int unsigned FIELD_LAST  = 20;
  localparam int unsigned NUM_FIELDS  = 4;

  // Characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned RAW_W    = 15;
  localparam int unsigned SCALED_W = 17;
  localparam int unsigned QUOT_W   = 18;

  // raw * 160 / 33 as one multiply: 160 * ceil(2^26 / 33), then drop 26 bits.
  // Exact for every product below 2^25.
  localparam int unsigned RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 29'd325376320;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned PROD_W      = RAW_W + RECIP_W;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_DONE = 3'b100
  } field_phase_t;

  typedef struct packed {
    logic [RAW_W-1:0] mag;
    logic             neg;
  } field_val_t;

endpackage

// ===== rtl/ascii_sensor_frame_parser_unit.sv =====
// ASCII sensor frame parser: byte-wise frame parse, header check and scaling.
// Depends on asfp_pkg.
//
// Usage:
//   Received bytes enter on rx_byte with in_valid/in_ready. While idle the
//   block waits for start_byte, then collects FRAME_BYTES bytes (start byte
//   included). Bytes 0..3 are checked against header_word, bytes 5..20 hold
//   four 4-character decimal fields parsed as they arrive. A frame with a good
//   header gives one request on the output channel (out_valid/out_ready):
//   the four integers and each divided by 3.3 with 4 fraction bits.
//   Throughput: one byte per cycle while in_ready is high. The parse of each
//   byte is done in the cycle it is taken; the final byte's request then
//   passes through the capture register, the per-field quotient multipliers
//   and the sign stage before it shows on out_valid.
//   When the receiver stalls, up to three requests wait in the capture,
//   quotient and output registers; in_ready drops only when all three are
//   full. Since a frame is at least 21 bytes this only happens under a long
//   stall.
//   Reset (rst, synchronous) returns the parser to idle, empties the result
//   stages and loads the register defaults. cfg_we writes cfg_data into the
//   register chosen by cfg_index at once.
module ascii_sensor_frame_parser_unit #(
  parameter int unsigned FRAME_BYTES = 22
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [asfp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [14:0]            raw_a,
  output logic signed [14:0]            raw_b,
  output logic signed [14:0]            raw_c,
  output logic signed [14:0]            raw_d,
  output logic signed [16:0]            scaled_a,
  output logic signed [16:0]            scaled_b,
  output logic signed [16:0]            scaled_c,
  output logic signed [16:0]            scaled_d
);
  import asfp_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

  // Configuration
  logic [7:0]  start_byte;
  logic [31:0] header_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= START_BYTE_RST;
      header_word <= HEADER_WORD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE:  start_byte  <= cfg_data[7:0];
        REG_HEADER_WORD: header_word <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser state
  logic                 in_frame, in_frame_next;
  logic [PosW-1:0]      pos, pos_next;
  logic                 hdr_ok, hdr_ok_next;
  logic [RAW_W-1:0]     acc [NUM_FIELDS];
  logic [RAW_W-1:0]     acc_next [NUM_FIELDS];
  logic                 neg [NUM_FIELDS];
  logic                 neg_next [NUM_FIELDS];
  field_phase_t         ph [NUM_FIELDS];
  field_phase_t         ph_next [NUM_FIELDS];
  logic                 cap_load;

  // Result stages
  logic                 cap_v;
  field_val_t           cap [NUM_FIELDS];
  logic                 mid_v;
  logic [QUOT_W-1:0]    mid_q [NUM_FIELDS];
  field_val_t           mid [NUM_FIELDS];
  logic [RAW_W-1:0]     out_raw [NUM_FIELDS];
  logic [SCALED_W-1:0]  out_scaled [NUM_FIELDS];

  logic accept, out_adv, mid_adv;

  assign in_ready = !(cap_v && mid_v && out_valid);
  assign accept   = in_valid && in_ready;
  assign out_adv  = !out_valid || out_ready;
  assign mid_adv  = !mid_v || out_adv;

  // Per-byte decode of the selected field
  logic             is_space, is_digit;
  logic [3:0]       digit;
  logic [PosW-1:0]  pos_off;
  logic [1:0]       fsel;
  logic             in_field;
  logic [7:0]       hdr_byte;
  logic [RAW_W+3:0] acc_x10;
  logic [RAW_W-1:0] f_acc;
  logic             f_neg;
  field_phase_t     f_ph;

  assign is_space = (rx_byte == CH_SPACE) || (rx_byte >= CH_TAB && rx_byte <= CH_CR);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit    = 4'(rx_byte - CH_ZERO);
  assign pos_off  = pos - PosW'(FIELD_FIRST);
  assign fsel     = pos_off[3:2];
  assign in_field = (pos >= PosW'(FIELD_FIRST)) && (pos <= PosW'(FIELD_LAST));
  assign hdr_byte = header_word[{~pos[1:0], 3'b000} +: 8];
  assign acc_x10  = {1'b0, acc[fsel], 3'b000} + {3'b000, acc[fsel], 1'b0};

  always_comb begin
    f_acc = acc[fsel];
    f_neg = neg[fsel];
    f_ph  = ph[fsel];
    unique case (ph[fsel])
      PH_SKIP: begin
        if (is_space) begin
          f_ph = PH_SKIP;
        end else if (rx_byte == CH_PLUS) begin
          f_ph = PH_NUM;
        end else if (rx_byte == CH_MINUS) begin
          f_neg = 1'b1;
          f_ph  = PH_NUM;
        end else if (is_digit) begin
          f_acc = RAW_W'(digit);
          f_ph  = PH_NUM;
        end else begin
          f_ph = PH_DONE;
        end
      end
      PH_NUM: begin
        if (is_digit) begin
          f_acc = acc_x10[RAW_W-1:0] + RAW_W'(digit);
        end else begin
          f_ph = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_frame_next = in_frame;
    pos_next      = pos;
    hdr_ok_next   = hdr_ok;
    cap_load      = 1'b0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      acc_next[i] = acc[i];
      neg_next[i] = neg[i];
      ph_next[i]  = ph[i];
    end
    if (accept) begin
      if (!in_frame) begin
        if (rx_byte == start_byte) begin
          in_frame_next = 1'b1;
          pos_next      = PosW'(1);
          hdr_ok_next   = (rx_byte == header_word[31:24]);
          for (int i = 0; i < NUM_FIELDS; i++) begin
            acc_next[i] = '0;
            neg_next[i] = 1'b0;
            ph_next[i]  = PH_SKIP;
          end
        end
      end else begin
        if (pos < PosW'(HDR_BYTES)) begin
          if (rx_byte != hdr_byte) hdr_ok_next = 1'b0;
        end else if (in_field) begin
          acc_next[fsel] = f_acc;
          neg_next[fsel] = f_neg;
          ph_next[fsel]  = f_ph;
        end
        pos_next = pos + PosW'(1);
        if (pos == LastPos) begin
          // Header is settled by now; the last field byte may land here
          cap_load      = hdr_ok;
          in_frame_next = 1'b0;
          pos_next      = '0;
          hdr_ok_next   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      pos      <= '0;
      hdr_ok   <= 1'b1;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        acc[i] <= '0;
        neg[i] <= 1'b0;
        ph[i]  <= PH_SKIP;
      end
    end else begin
      in_frame <= in_frame_next;
      pos      <= pos_next;
      hdr_ok   <= hdr_ok_next;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        acc[i] <= acc_next[i];
        neg[i] <= neg_next[i];
        ph[i]  <= ph_next[i];
      end
    end
  end

  // Capture stage: hold the finished fields
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_v <= 1'b0;
    end else if (cap_load) begin
      cap_v <= 1'b1;
    end else if (mid_adv) begin
      cap_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_load) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        cap[i].mag <= acc_next[i];
        cap[i].neg <= neg_next[i];
      end
    end
  end

  // Quotient stage: magnitude * 160 / 33 by reciprocal multiply, one lane per field
  logic [PROD_W-1:0] prod [NUM_FIELDS];

  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      prod[i] = PROD_W'(cap[i].mag) * PROD_W'(RECIP_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_v <= 1'b0;
    end else if (mid_adv) begin
      mid_v <= cap_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        mid_q[i] <= prod[i][RECIP_SHIFT +: QUOT_W];
        mid[i]   <= cap[i];
      end
    end
  end

  // Sign stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= mid_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        out_raw[i]    <= mid[i].neg ? RAW_W'(-mid[i].mag) : mid[i].mag;
        out_scaled[i] <= mid[i].neg ? SCALED_W'(-mid_q[i][SCALED_W-1:0])
                                    : mid_q[i][SCALED_W-1:0];
      end
    end
  end

  assign raw_a    = out_raw[0];
  assign raw_b    = out_raw[1];
  assign raw_c    = out_raw[2];
  assign raw_d    = out_raw[3];
  assign scaled_a = out_scaled[0];
  assign scaled_b = out_scaled[1];
  assign scaled_c = out_scaled[2];
  assign scaled_d = out_scaled[3];

  // Checks
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (pos <= LastPos))
    else $error("byte position ran past the frame end");

  a_frame_end_capture: assert property (@(posedge clk) disable iff (rst)
    (accept && in_frame && (pos == LastPos) && hdr_ok) |=> cap_v)
    else $error("good frame did not reach the capture stage");

  a_quot_lo: assert property (@(posedge clk) disable iff (rst)
    mid_v |-> ((25'(mid_q[0]) * 25'd33) <= (25'(mid[0].mag) * 25'd160)))
    else $error("quotient too large");

  a_quot_hi: assert property (@(posedge clk) disable iff (rst)
    mid_v |-> ((25'(mid[0].mag) * 25'd160) < ((25'(mid_q[0]) + 25'd1) * 25'd33)))
    else $error("quotient too small");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ascii_sensor_frame_parser_unit: byte frames in, sensor readings out.
// Depends on asfp_pkg and the RTL; a built-in frame parser predicts every reading.
module tb_top;
  import asfp_pkg::*;

  localparam int unsigned FRAME_BYTES = 22;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [3:0][RAW_W-1:0]    raw;
    logic [3:0][SCALED_W-1:0] scaled;
  } reading_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_START_BYTE;
  logic [31:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [14:0]  raw_a, raw_b, raw_c, raw_d;
  logic signed [16:0]  scaled_a, scaled_b, scaled_c, scaled_d;

  ascii_sensor_frame_parser_unit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .raw_a(raw_a), .raw_b(raw_b), .raw_c(raw_c), .raw_d(raw_d),
    .scaled_a(scaled_a), .scaled_b(scaled_b), .scaled_c(scaled_c), .scaled_d(scaled_d)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shared between processes
  logic [7:0]   rx_stream [$];
  reading_t     due_readings [$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  bit           idle_on = 1'b1;
  bit           byte_taken = 1'b0;
  bit           hold_req = 1'b0;

  // Append one byte to the pending stream
  task automatic queue_byte(input logic [7:0] b);
    rx_stream.insert(rx_stream.size(), b);
  endtask

  // Parser mirror: registers and frame state
  logic [7:0]   start_cfg = START_BYTE_RST;
  logic [31:0]  hdr_cfg = HEADER_WORD_RST;
  bit           in_frame_m = 1'b0;
  logic [4:0]   frame_pos = '0;
  bit           hdr_ok = 1'b1;
  logic [RAW_W-1:0] fld_acc [4];
  bit           fld_neg [4];
  field_phase_t fld_phase [4];

  task automatic clear_fields();
    for (int i = 0; i < 4; i++) begin
      fld_acc[i] = '0;
      fld_neg[i] = 1'b0;
      fld_phase[i] = PH_SKIP;
    end
  endtask

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Advance the mirror by one byte; queue a reading when a good frame completes.
  task automatic parse_rx_byte(input logic [7:0] c);
    int unsigned pos, f, nxt, mag, q, rawv, scv;
    reading_t r;
    if (!in_frame_m) begin
      if (c == start_cfg) begin
        clear_fields();
        hdr_ok = (c == hdr_cfg[31:24]);
        frame_pos = 5'd1;
        in_frame_m = 1'b1;
      end
    end else begin
      pos = 32'(frame_pos);
      if (pos < HDR_BYTES) begin
        if (c != hdr_cfg[8*(3-pos) +: 8]) hdr_ok = 1'b0;
      end else if (pos >= FIELD_FIRST && pos <= FIELD_LAST) begin
        f = (pos - FIELD_FIRST) / 4;
        case (fld_phase[f])
          PH_SKIP: begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
              // skip leading whitespace
            end else if (c == CH_PLUS) begin
              fld_phase[f] = PH_NUM;
            end else if (c == CH_MINUS) begin
              fld_neg[f] = 1'b1;
              fld_phase[f] = PH_NUM;
            end else if (is_digit(c)) begin
              fld_acc[f] = RAW_W'(c - CH_ZERO);
              fld_phase[f] = PH_NUM;
            end else begin
              fld_phase[f] = PH_DONE;
            end
          end
          PH_NUM: begin
            if (is_digit(c)) begin
              nxt = 32'(fld_acc[f]) * 10 + 32'(c - CH_ZERO);
              fld_acc[f] = nxt[RAW_W-1:0];
            end else begin
              fld_phase[f] = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      frame_pos = frame_pos + 5'd1;
      if (pos + 1 >= FRAME_BYTES) begin
        if (hdr_ok) begin
          for (int i = 0; i < 4; i++) begin
            mag = 32'(fld_acc[i]);
            q = (mag * 160) / 33;
            rawv = fld_neg[i] ? 0 - mag : mag;
            scv = fld_neg[i] ? 0 - q : q;
            r.raw[i] = rawv[RAW_W-1:0];
            r.scaled[i] = scv[SCALED_W-1:0];
          end
          due_readings.insert(due_readings.size(), r);
        end
        in_frame_m = 1'b0;
        frame_pos = '0;
        hdr_ok = 1'b1;
        clear_fields();
      end
    end
  endtask

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned next_gap();
    int unsigned pick;
    if (!idle_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input side: count a byte in when the handshake completes
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      parse_rx_byte(rx_byte);
      byte_taken = 1'b1;
    end
  end

  // Byte sender
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (in_valid && !byte_taken) begin
      // hold the offered byte
    end else begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        send_gap = next_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (rx_stream.size() > 0) begin
        in_valid <= 1'b1;
        rx_byte <= rx_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Reading receiver with random stalls and the occasional long hold-off
  int unsigned hold_cnt = 0;
  int unsigned stall_cnt = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) stall_cnt = next_gap();
    end
  end

  // Reading checker
  always @(posedge clk) begin
    reading_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.raw = {raw_d, raw_c, raw_b, raw_a};
      got.scaled = {scaled_d, scaled_c, scaled_b, scaled_a};
      if (due_readings.size() == 0) begin
        mismatches++;
        $display("%0t: reading with none due: raw %0d %0d %0d %0d", $time,
                 raw_a, raw_b, raw_c, raw_d);
      end else begin
        want = due_readings.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.raw[i] !== want.raw[i]) begin
            mismatches++;
            $display("%0t: raw[%0d] expected %0d got %0d", $time, i,
                     $signed(want.raw[i]), $signed(got.raw[i]));
          end
          if (got.scaled[i] !== want.scaled[i]) begin
            mismatches++;
            $display("%0t: scaled[%0d] expected %0d got %0d", $time, i,
                     $signed(want.scaled[i]), $signed(got.scaled[i]));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Register write; the mirror follows once the write edge has passed
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_BYTE) start_cfg = val[7:0];
    else hdr_cfg = val;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (rx_stream.size() != 0 || in_valid || due_readings.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Tab, LF, VT, FF, CR or space
  function automatic logic [7:0] ws_char();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  function automatic logic [7:0] any_field_char();
    case ($urandom_range(0, 7))
      0, 1, 2: return 8'(CH_ZERO + $urandom_range(0, 9));
      3:       return ws_char();
      4:       return CH_PLUS;
      5:       return CH_MINUS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_field();
    int unsigned lead;
    logic [7:0] ch;
    if ($urandom_range(0, 2) == 0) begin
      for (int k = 0; k < 4; k++) queue_byte(any_field_char());
    end else begin
      lead = $urandom_range(0, 4) < 3 ? 0 : $urandom_range(1, 2);
      for (int k = 0; k < 4; k++) begin
        if (k < lead) ch = ws_char();
        else if (k == lead && $urandom_range(0, 2) == 0)
          ch = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
        else if ($urandom_range(0, 15) == 0) ch = any_field_char();
        else ch = 8'(CH_ZERO + $urandom_range(0, 9));
        queue_byte(ch);
      end
    end
  endtask

  task automatic push_frame();
    logic [7:0] hb [4];
    int unsigned bad;
    hb[0] = start_cfg;
    hb[1] = hdr_cfg[23:16];
    hb[2] = hdr_cfg[15:8];
    hb[3] = hdr_cfg[7:0];
    if ($urandom_range(0, 7) == 0) begin
      bad = $urandom_range(1, 3);
      hb[bad] = hb[bad] ^ (8'd1 << $urandom_range(0, 7));
    end
    for (int k = 0; k < 4; k++) queue_byte(hb[k]);
    queue_byte($urandom_range(0, 3) == 0 ? start_cfg : 8'($urandom_range(0, 255)));
    for (int k = 0; k < 4; k++) push_field();
    for (int k = FIELD_LAST + 1; k < FRAME_BYTES; k++)
      queue_byte(8'($urandom_range(0, 255)));
  endtask

  // Mostly whole frames, with stray bytes between them
  task automatic queue_traffic(input int unsigned n_bytes, input bit idle);
    int unsigned target;
    idle_on = idle;
    target = rx_stream.size() + n_bytes;
    while (rx_stream.size() < target) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
      push_frame();
    end
  endtask

  initial begin
    logic [31:0] rnd;
    logic [7:0] opening [24];
    clear_fields();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Default registers: limits of the fields, a stray start byte in the unused
    // slot, a field cut short by a letter, and a lone sign between spaces.
    opening = '{8'h31, 8'h31, 8'h31, 8'h36, 8'h31,
                CH_NINE, CH_NINE, CH_NINE, CH_NINE,
                CH_MINUS, CH_NINE, CH_NINE, CH_NINE,
                CH_TAB, CH_PLUS, CH_ZERO + 8'd7, 8'h78,
                CH_SPACE, CH_SPACE, CH_MINUS, CH_SPACE,
                8'hFF, 8'h00, 8'h7F};
    idle_on = 1'b1;
    foreach (opening[k]) queue_byte(opening[k]);
    wait_drained();
    queue_traffic(400, 1'b1);
    wait_drained();

    rnd = $urandom;
    write_reg(REG_START_BYTE, {rnd[31:8], 8'h00});
    write_reg(REG_HEADER_WORD, 32'h0000_0000);
    queue_traffic(300, 1'b1);
    wait_drained();

    write_reg(REG_START_BYTE, 32'h0000_00FF);
    write_reg(REG_HEADER_WORD, 32'hFFFF_FFFF);
    queue_traffic(300, 1'b0);
    wait_drained();

    // Long receiver hold-off with the sender running flat out
    rnd = $urandom;
    write_reg(REG_START_BYTE, 32'h0000_0024);
    write_reg(REG_HEADER_WORD, {8'h24, rnd[23:0]});
    @(posedge clk);
    hold_req = 1'b1;
    queue_traffic(450, 1'b0);
    wait_drained();

    // Start byte that can never match the header: frames give nothing
    rnd = $urandom;
    write_reg(REG_START_BYTE, 32'h0000_0041);
    write_reg(REG_HEADER_WORD, {8'h42, rnd[23:0]});
    queue_traffic(150, 1'b1);
    wait_drained();

    write_reg(REG_START_BYTE, {24'h0, START_BYTE_RST});
    write_reg(REG_HEADER_WORD, HEADER_WORD_RST);
    queue_traffic(500, 1'b1);
    wait_drained();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/asfp_pkg.sv
rtl/ascii_sensor_frame_parser_unit.sv
tb/tb_top.sv
